// ===== hdl/ndrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ndrm_pkg
// Shared types, codes and sizing constants for the descriptor ring manager.
// ----------------------------------------------------------------------------
package ndrm_pkg;

   localparam int TX_RING_SIZE = 256;
   localparam int RX_RING_SIZE = 256;
   localparam int FLUSH_COUNT  = 32;
   localparam int BUFFER_BYTES = 2048;

   localparam int TX_IDX_W  = $clog2(TX_RING_SIZE);
   localparam int RX_IDX_W  = $clog2(RX_RING_SIZE);
   localparam int BUF_SHIFT = $clog2(BUFFER_BYTES);
   localparam int FLUSH_W   = (FLUSH_COUNT > 1) ? $clog2(FLUSH_COUNT) : 1;
   localparam int HEAD_W    = 8;
   localparam int TX_CMP_W  = (TX_IDX_W > HEAD_W) ? TX_IDX_W : HEAD_W;

   localparam int ADDR_W    = 48;
   localparam int FLEN_W    = 11;
   localparam int RXLEN_W   = 16;
   localparam int SLOT_W    = 8;
   localparam int HIGH_W    = 64;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 144;

   localparam logic [FLEN_W-1:0] MAX_FRAME_RESET = 11'd1500;
   localparam logic [31:0] CMD_DTYP_ADV = 32'd3 << 20;
   localparam logic [31:0] CMD_FLAGS    = ((32'd1 << 5) | (32'd1 << 1) | 32'd1) << 24;
   localparam int          PAYLEN_SHIFT = 46 - 32;

   // rx tail resets to ring size minus one, so its batch phase starts there too
   localparam logic [FLUSH_W-1:0] RX_MOD_RESET = FLUSH_W'((RX_RING_SIZE - 1) % FLUSH_COUNT);
   localparam logic [FLUSH_W-1:0] FLUSH_LAST   = FLUSH_W'(FLUSH_COUNT - 1);
   localparam logic [TX_IDX_W-1:0] TX_LAST     = TX_IDX_W'(TX_RING_SIZE - 1);
   localparam logic [RX_IDX_W-1:0] RX_LAST     = RX_IDX_W'(RX_RING_SIZE - 1);

   typedef enum logic [1:0] {
      MODE_SEND  = 2'd0,
      MODE_FLUSH = 2'd1,
      MODE_RECV  = 2'd2,
      MODE_IDLE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_LEN_REJECT = 3'd1,
      STAT_TX_FULL    = 3'd2,
      STAT_RX_EMPTY   = 3'd3,
      STAT_RX_OVERSZ  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_TX_BASE  = 2'd0,
      CSR_RX_BASE  = 2'd1,
      CSR_HDR_BASE = 2'd2,
      CSR_MAX_LEN  = 2'd3
   } csr_idx_type;

   typedef enum logic {
      TAIL_TX = 1'b0,
      TAIL_RX = 1'b1
   } tail_ring_type;

   typedef enum logic {
      CTRL_EMPTY,
      CTRL_FULL
   } ctrl_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] tx_base;
      logic [ADDR_W-1:0] rx_base;
      logic [ADDR_W-1:0] hdr_base;
      logic [FLEN_W-1:0] max_len;
   } cfg_type;

   typedef struct packed {
      logic load;
   } ctrl_cmd_type;

endpackage

// ===== hdl/ndrm_csr.sv =====
// ----------------------------------------------------------------------------
// ndrm_csr
// Configuration registers: buffer bases and frame length limit.
// ----------------------------------------------------------------------------
module ndrm_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [ndrm_pkg::ADDR_W-1:0] csr_wdata,
   output ndrm_pkg::cfg_type       cfg
);
   import ndrm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TX_BASE:  cfg_in.tx_base  = csr_wdata;
            CSR_RX_BASE:  cfg_in.rx_base  = csr_wdata;
            CSR_HDR_BASE: cfg_in.hdr_base = csr_wdata;
            CSR_MAX_LEN:  cfg_in.max_len  = csr_wdata[FLEN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_base  <= '0;
         cfg_ff.rx_base  <= '0;
         cfg_ff.hdr_base <= '0;
         cfg_ff.max_len  <= MAX_FRAME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/ndrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ndrm_ctrl
// Handshake controller: tracks whether the response register holds a result.
// ----------------------------------------------------------------------------
module ndrm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output ndrm_pkg::ctrl_cmd_type cmd
);
   import ndrm_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      rsp_tvalid = 1'b0;
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         CTRL_EMPTY: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) begin
               state_in = CTRL_FULL;
            end
         end
         CTRL_FULL: begin
            rsp_tvalid = 1'b1;
            // a new request may enter in the same cycle the held result leaves
            req_tready = rsp_tready;
            cmd.load   = req_tvalid && rsp_tready;
            if (rsp_tready && !req_tvalid) begin
               state_in = CTRL_EMPTY;
            end
         end
      endcase
   end

endmodule

// ===== hdl/ndrm_dpath.sv =====
// ----------------------------------------------------------------------------
// ndrm_dpath
// Ring index state, descriptor packing, doorbell batching, response register.
// ----------------------------------------------------------------------------
module ndrm_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ndrm_pkg::ctrl_cmd_type          cmd,
   input  ndrm_pkg::cfg_type               cfg,
   input  logic [1:0]                      req_tuser,
   input  logic [ndrm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic [2:0]                      rsp_tuser,
   output logic [ndrm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ndrm_pkg::*;

   logic [TX_IDX_W-1:0] tx_next_ff, tx_next_in;
   logic [TX_IDX_W-1:0] tx_tail_ff, tx_tail_in;
   logic [HEAD_W-1:0]   tx_head_ff, tx_head_in;
   logic [FLUSH_W-1:0]  tx_mod_ff, tx_mod_in;
   logic [RX_IDX_W-1:0] rx_next_ff, rx_next_in;
   logic [RX_IDX_W-1:0] rx_tail_ff, rx_tail_in;
   logic [FLUSH_W-1:0]  rx_mod_ff, rx_mod_in;

   logic [2:0]            rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   mode_type           mode;
   logic [FLEN_W-1:0]  send_len;
   logic [HEAD_W-1:0]  head_snap;
   logic [RXLEN_W-1:0] rx_len;

   logic [TX_IDX_W-1:0] tx_nxt;
   logic [RX_IDX_W-1:0] rx_nxt;
   logic [RX_IDX_W-1:0] rx_tail_nxt;
   logic [FLUSH_W-1:0]  tx_mod_nxt;
   logic [FLUSH_W-1:0]  rx_mod_nxt;
   logic                tx_hit;
   logic [31:0]         cmd_word;
   logic [31:0]         pay_word;
   logic [ADDR_W-1:0]   tx_addr;
   logic [ADDR_W-1:0]   rx_addr;

   status_type         status;
   logic [FLEN_W-1:0]  res_len;
   logic [SLOT_W-1:0]  slot;
   logic               desc_wr;
   logic [ADDR_W-1:0]  desc_addr;
   logic [HIGH_W-1:0]  desc_high;
   logic               tail_wr;
   tail_ring_type      tail_ring;
   logic [SLOT_W-1:0]  tail_val;

   assign mode      = mode_type'(req_tuser);
   assign send_len  = req_tdata[10:0];
   assign head_snap = req_tdata[18:11];
   assign rx_len    = req_tdata[34:19];

   assign tx_nxt      = (tx_next_ff == TX_LAST) ? '0 : tx_next_ff + 1'b1;
   assign rx_nxt      = (rx_next_ff == RX_LAST) ? '0 : rx_next_ff + 1'b1;
   assign rx_tail_nxt = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + 1'b1;

   // batch phase counters follow index mod FLUSH_COUNT, restarting at ring wrap
   assign tx_mod_nxt = (tx_nxt == '0) ? '0 :
                       (tx_mod_ff == FLUSH_LAST) ? '0 : tx_mod_ff + 1'b1;
   assign rx_mod_nxt = (rx_tail_nxt == '0) ? '0 :
                       (rx_mod_ff == FLUSH_LAST) ? '0 : rx_mod_ff + 1'b1;

   assign tx_hit   = TX_CMP_W'(tx_nxt) == TX_CMP_W'(tx_head_ff);
   assign cmd_word = 32'(send_len) | CMD_DTYP_ADV | CMD_FLAGS;
   assign pay_word = 32'(send_len) << PAYLEN_SHIFT;
   assign tx_addr  = cfg.tx_base + (ADDR_W'(tx_next_ff) << BUF_SHIFT);
   assign rx_addr  = cfg.rx_base + (ADDR_W'(rx_next_ff) << BUF_SHIFT);

   always_comb begin
      tx_next_in = tx_next_ff;
      tx_tail_in = tx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_mod_in  = tx_mod_ff;
      rx_next_in = rx_next_ff;
      rx_tail_in = rx_tail_ff;
      rx_mod_in  = rx_mod_ff;
      status     = STAT_OK;
      res_len    = '0;
      slot       = '0;
      desc_wr    = 1'b0;
      desc_addr  = '0;
      desc_high  = '0;
      tail_wr    = 1'b0;
      tail_ring  = TAIL_TX;
      tail_val   = '0;
      unique case (mode)
         MODE_SEND: begin
            slot = SLOT_W'(tx_next_ff);
            if (send_len > cfg.max_len) begin
               status = STAT_LEN_REJECT;
            end else begin
               if (tx_hit) begin
                  tx_head_in = head_snap;
               end
               if (tx_hit && (TX_CMP_W'(tx_nxt) == TX_CMP_W'(head_snap))) begin
                  status = STAT_TX_FULL;
               end else begin
                  desc_wr    = 1'b1;
                  desc_addr  = tx_addr;
                  desc_high  = {pay_word, cmd_word};
                  tx_next_in = tx_nxt;
                  tx_mod_in  = tx_mod_nxt;
                  if ((tx_mod_nxt == '0) && (tx_tail_ff != tx_nxt)) begin
                     tx_tail_in = tx_nxt;
                     tail_wr    = 1'b1;
                     tail_val   = SLOT_W'(tx_nxt);
                  end
               end
            end
         end
         MODE_FLUSH: begin
            if (tx_tail_ff != tx_next_ff) begin
               tx_tail_in = tx_next_ff;
               tail_wr    = 1'b1;
               tail_val   = SLOT_W'(tx_next_ff);
            end
         end
         MODE_RECV: begin
            slot = SLOT_W'(rx_next_ff);
            if (rx_len == '0) begin
               status = STAT_RX_EMPTY;
            end else if (rx_len > RXLEN_W'(cfg.max_len)) begin
               status = STAT_RX_OVERSZ;
            end else begin
               res_len    = rx_len[FLEN_W-1:0];
               desc_wr    = 1'b1;
               desc_addr  = rx_addr;
               desc_high  = HIGH_W'(cfg.hdr_base);
               rx_next_in = rx_nxt;
               rx_tail_in = rx_tail_nxt;
               rx_mod_in  = rx_mod_nxt;
               if (rx_mod_nxt == '0) begin
                  tail_wr   = 1'b1;
                  tail_ring = TAIL_RX;
                  tail_val  = SLOT_W'(rx_tail_nxt);
               end
            end
         end
         MODE_IDLE: begin
         end
      endcase
   end

   always_comb begin
      rsp_user_in = status;
      rsp_data_in = RSP_DATA_W'({tail_val, tail_ring, tail_wr, desc_high, desc_addr,
                                 desc_wr, slot, res_len});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_next_ff <= '0;
         tx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_mod_ff  <= '0;
         rx_next_ff <= '0;
         rx_tail_ff <= RX_LAST;
         rx_mod_ff  <= RX_MOD_RESET;
      end else if (cmd.load) begin
         tx_next_ff <= tx_next_in;
         tx_tail_ff <= tx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_mod_ff  <= tx_mod_in;
         rx_next_ff <= rx_next_in;
         rx_tail_ff <= rx_tail_in;
         rx_mod_ff  <= rx_mod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_user_ff <= rsp_user_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tuser = rsp_user_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== hdl/nic_descriptor_ring_manager.sv =====
// a response is presented in the cycle after its request is accepted
// throughput: one request per cycle with rsp_tready high; the single
// response register takes a new request in the cycle the held one is taken
// reset: synchronous, clears ring indices and head cache, sets rx tail to
// ring size minus one, buffer bases to zero and frame limit to 1500
// ----------------------------------------------------------------------------
// nic_descriptor_ring_manager
// Host-side manager of a NIC transmit ring and receive ring with batched
// tail doorbells.
// ----------------------------------------------------------------------------
module nic_descriptor_ring_manager (
   input  logic                            clock,
   input  logic                            reset,
   // request: tuser = mode
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [1:0]                      req_tuser,
   // request: send_length, head_snapshot, rx_desc_length
   input  logic [ndrm_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: tuser = status
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2:0]                      rsp_tuser,
   // response: result_length, slot_index, desc_write, desc_addr, desc_high,
   // tail_write, tail_ring, tail_value
   output logic [ndrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [ndrm_pkg::ADDR_W-1:0]     csr_wdata
);
   import ndrm_pkg::*;

   cfg_type      cfg;
   ctrl_cmd_type cmd;

   ndrm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ndrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ndrm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== test/nic_descriptor_ring_manager_tb.sv =====
// ----------------------------------------------------------------------------
// nic_descriptor_ring_manager_tb
// Drives send, flush, receive and unused requests into the ring manager and
// checks every response field against a cycle-free model of both rings,
// under several register settings and with random gaps on both sides.
// ----------------------------------------------------------------------------
module nic_descriptor_ring_manager_tb;
   import ndrm_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int ITEMS_A_PHASE = 65;
   localparam int RANDOM_PHASES = 8;
   localparam int N_DIRECTED    = 16;
   localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

   typedef enum int {
      PACE_STEADY,
      PACE_SENDER_GAPS,
      PACE_RECEIVER_STALLS,
      PACE_BOTH
   } pacing_type;

   typedef struct {
      status_type        status;
      logic [FLEN_W-1:0] rx_len;
      logic [SLOT_W-1:0] slot;
      logic              desc_wr;
      logic [ADDR_W-1:0] addr;
      logic [HIGH_W-1:0] high;
      logic              tail_wr;
      logic              tail_sel;
      logic [SLOT_W-1:0] tail_val;
   } ring_outcome_type;

   typedef struct packed {
      mode_type           op;
      logic [FLEN_W-1:0]  send_len;
      logic [HEAD_W-1:0]  head_snap;
      logic [RXLEN_W-1:0] rx_len;
      logic               pinned;
      status_type         pinned_status;
   } directed_row_type;

   // pinned rows carry a status that is plain from the request alone
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{MODE_SEND,  11'd0,    8'd0,   16'd0,     1'b1, STAT_OK},
      '{MODE_SEND,  11'd1500, 8'd0,   16'd0,     1'b1, STAT_OK},
      '{MODE_SEND,  11'd1501, 8'd0,   16'd0,     1'b1, STAT_LEN_REJECT},
      '{MODE_SEND,  11'd2047, 8'd255, 16'd65535, 1'b1, STAT_LEN_REJECT},
      '{MODE_FLUSH, 11'd0,    8'd0,   16'd0,     1'b1, STAT_OK},
      '{MODE_FLUSH, 11'd0,    8'd0,   16'd0,     1'b1, STAT_OK},
      '{MODE_RECV,  11'd0,    8'd0,   16'd0,     1'b1, STAT_RX_EMPTY},
      '{MODE_RECV,  11'd0,    8'd0,   16'd65535, 1'b1, STAT_RX_OVERSZ},
      '{MODE_RECV,  11'd0,    8'd0,   16'd1501,  1'b1, STAT_RX_OVERSZ},
      // rx tail wraps from its reset value to zero, so a doorbell goes out
      '{MODE_RECV,  11'd0,    8'd0,   16'd1500,  1'b1, STAT_OK},
      '{MODE_RECV,  11'd0,    8'd0,   16'd1,     1'b0, STAT_OK},
      '{MODE_IDLE,  11'd2047, 8'd255, 16'd65535, 1'b1, STAT_OK},
      '{MODE_SEND,  11'd46,   8'd170, 16'd0,     1'b0, STAT_OK},
      '{MODE_SEND,  11'd1024, 8'd85,  16'd21845, 1'b0, STAT_OK},
      '{MODE_FLUSH, 11'd0,    8'd0,   16'd0,     1'b0, STAT_OK},
      '{MODE_RECV,  11'd0,    8'd0,   16'd2047,  1'b1, STAT_RX_OVERSZ}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [2:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [ADDR_W-1:0]     csr_wdata;

   // model copy of the registers and ring indices
   logic [ADDR_W-1:0] tx_base;
   logic [ADDR_W-1:0] rx_base;
   logic [ADDR_W-1:0] hdr_base;
   logic [FLEN_W-1:0] frame_limit;
   int                tx_next;
   int                tx_tail;
   int                head_cache;
   int                rx_next;
   int                rx_tail;

   ring_outcome_type awaited_outcomes [$];
   ring_outcome_type want;
   pacing_type       pacing;
   int               failures;
   int               cycle_count;

   nic_descriptor_ring_manager DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void reset_rings();
      tx_base     = '0;
      rx_base     = '0;
      hdr_base    = '0;
      frame_limit = MAX_FRAME_RESET;
      tx_next     = 0;
      tx_tail     = 0;
      head_cache  = 0;
      rx_next     = 0;
      rx_tail     = RX_RING_SIZE - 1;
   endfunction

   function automatic void set_register(csr_idx_type idx, logic [ADDR_W-1:0] value);
      case (idx)
         CSR_TX_BASE:  tx_base = value;
         CSR_RX_BASE:  rx_base = value;
         CSR_HDR_BASE: hdr_base = value;
         CSR_MAX_LEN:  frame_limit = value[FLEN_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void push_tx_tail(ref ring_outcome_type r);
      if (tx_tail != tx_next) begin
         tx_tail    = tx_next;
         r.tail_wr  = 1'b1;
         r.tail_sel = TAIL_TX;
         r.tail_val = SLOT_W'(tx_tail);
      end
   endfunction

   // advances both rings by one request and returns the response it causes
   function automatic ring_outcome_type advance_rings(mode_type op, logic [FLEN_W-1:0] send_len,
                                                      logic [HEAD_W-1:0] head_snap,
                                                      logic [RXLEN_W-1:0] rx_len);
      ring_outcome_type r;
      int               nxt;
      logic [31:0]      cmd;
      logic [31:0]      pay;
      r = '{STAT_OK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0, '0};
      case (op)
         MODE_SEND: begin
            nxt    = (tx_next + 1) % TX_RING_SIZE;
            r.slot = SLOT_W'(tx_next);
            if (send_len > frame_limit) begin
               r.status = STAT_LEN_REJECT;
            end else begin
               if (nxt == head_cache) head_cache = int'(head_snap);
               if (nxt == head_cache) begin
                  r.status = STAT_TX_FULL;
               end else begin
                  cmd       = 32'(send_len) | CMD_DTYP_ADV | CMD_FLAGS;
                  pay       = 32'(send_len) << PAYLEN_SHIFT;
                  r.desc_wr = 1'b1;
                  r.addr    = tx_base + ADDR_W'(tx_next) * ADDR_W'(BUFFER_BYTES);
                  r.high    = {pay, cmd};
                  tx_next   = nxt;
                  if (tx_next % FLUSH_COUNT == 0) push_tx_tail(r);
               end
            end
         end
         MODE_FLUSH: push_tx_tail(r);
         MODE_RECV: begin
            r.slot = SLOT_W'(rx_next);
            if (rx_len == 0) begin
               r.status = STAT_RX_EMPTY;
            end else if (rx_len > RXLEN_W'(frame_limit)) begin
               r.status = STAT_RX_OVERSZ;
            end else begin
               r.rx_len  = rx_len[FLEN_W-1:0];
               r.desc_wr = 1'b1;
               r.addr    = rx_base + ADDR_W'(rx_next) * ADDR_W'(BUFFER_BYTES);
               r.high    = HIGH_W'(hdr_base);
               rx_next   = (rx_next + 1) % RX_RING_SIZE;
               rx_tail   = (rx_tail + 1) % RX_RING_SIZE;
               if (rx_tail % FLUSH_COUNT == 0) begin
                  r.tail_wr  = 1'b1;
                  r.tail_sel = TAIL_RX;
                  r.tail_val = SLOT_W'(rx_tail);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bit sender_gap();
      case (pacing)
         PACE_SENDER_GAPS: return $urandom_range(0, 99) < 55;
         PACE_BOTH:        return $urandom_range(0, 99) < 12;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stall();
      case (pacing)
         PACE_RECEIVER_STALLS: return $urandom_range(0, 99) < 55;
         PACE_BOTH:            return $urandom_range(0, 99) < 12;
         default:              return 1'b0;
      endcase
   endfunction

   // leaves the caller at a falling edge with valid still high
   task automatic send_request(mode_type op, logic [FLEN_W-1:0] send_len,
                               logic [HEAD_W-1:0] head_snap, logic [RXLEN_W-1:0] rx_len,
                               bit pinned, status_type pinned_status);
      ring_outcome_type r;
      while (sender_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({rx_len, head_snap, send_len});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = advance_rings(op, send_len, head_snap, rx_len);
      if (pinned) r.status = pinned_status;
      awaited_outcomes.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_registers(logic [ADDR_W-1:0] v_tx, logic [ADDR_W-1:0] v_rx,
                                  logic [ADDR_W-1:0] v_hdr, logic [ADDR_W-1:0] v_max);
      logic [ADDR_W-1:0] values [4];
      values = '{v_tx, v_rx, v_hdr, v_max};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_idx_type'(i);
         csr_wdata <= values[i];
         set_register(csr_idx_type'(i), values[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_request();
      mode_type op;
      int       pick;
      int       slen;
      int       snap;
      int       rlen;
      pick = $urandom_range(0, 99);
      if (pick < 65) op = MODE_SEND;
      else if (pick < 75) op = MODE_FLUSH;
      else if (pick < 95) op = MODE_RECV;
      else op = MODE_IDLE;

      pick = $urandom_range(0, 99);
      if (pick < 75) slen = $urandom_range(0, int'(frame_limit));
      else if (pick < 85) slen = int'(frame_limit) + $urandom_range(0, 1);
      else slen = $urandom_range(0, 2047);

      // head near the next slot so that the ring keeps filling up
      pick = $urandom_range(0, 9);
      if (pick < 6) snap = tx_next + $urandom_range(1, 12);
      else if (pick < 8) snap = tx_next + 1;
      else snap = $urandom_range(0, 255);

      pick = $urandom_range(0, 99);
      if (pick < 10) rlen = 0;
      else if (pick < 80) rlen = $urandom_range(1, int'(frame_limit));
      else if (pick < 90) rlen = int'(frame_limit) + $urandom_range(0, 1);
      else rlen = $urandom_range(0, 65535);

      send_request(op, FLEN_W'(slen), HEAD_W'(snap), RXLEN_W'(rlen), 1'b0, STAT_OK);
   endtask

   function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, expected, actual);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: response with nothing awaited: status %h data %h",
                     $time, rsp_tuser, rsp_tdata);
            failures++;
         end else begin
            want = awaited_outcomes.pop_front();
            check_field("status",        64'(want.status),   64'(rsp_tuser));
            check_field("result_length", 64'(want.rx_len),   64'(rsp_tdata[10:0]));
            check_field("slot_index",    64'(want.slot),     64'(rsp_tdata[18:11]));
            check_field("desc_write",    64'(want.desc_wr),  64'(rsp_tdata[19]));
            check_field("desc_addr",     64'(want.addr),     64'(rsp_tdata[67:20]));
            check_field("desc_high",     want.high,          rsp_tdata[131:68]);
            check_field("tail_write",    64'(want.tail_wr),  64'(rsp_tdata[132]));
            check_field("tail_ring",     64'(want.tail_sel), 64'(rsp_tdata[133]));
            check_field("tail_value",    64'(want.tail_val), 64'(rsp_tdata[141:134]));
         end
      end
   end

   always @(negedge clock) rsp_tready <= !receiver_stall();

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] max_word;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = '0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      failures    = 0;
      cycle_count = 0;
      pacing      = PACE_STEADY;
      reset_rings();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].send_len, DIRECTED_ROWS[i].head_snap,
                      DIRECTED_ROWS[i].rx_len, DIRECTED_ROWS[i].pinned,
                      DIRECTED_ROWS[i].pinned_status);
      end

      for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
         drain_responses();
         case (phase)
            1: write_registers(ADDR_ONES, '0, ADDR_ONES, ADDR_W'(2047));
            // zero frame limit, with junk above the register width
            2: write_registers('0, ADDR_ONES, '0, ADDR_W'($urandom) << FLEN_W);
            default: begin
               max_word = ADDR_W'({$urandom, $urandom});
               if ($urandom_range(0, 1) == 0) max_word[FLEN_W-1:0] = MAX_FRAME_RESET;
               write_registers(ADDR_W'({$urandom, $urandom}), ADDR_W'({$urandom, $urandom}),
                               ADDR_W'({$urandom, $urandom}), max_word);
            end
         endcase
         pacing = pacing_type'(phase % 4);
         for (int n = 0; n < ITEMS_A_PHASE; n++) random_request();
      end

      drain_responses();
      repeat (10) @(negedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/ndrm_pkg.sv
hdl/ndrm_csr.sv
hdl/ndrm_ctrl.sv
hdl/ndrm_dpath.sv
hdl/nic_descriptor_ring_manager.sv
test/nic_descriptor_ring_manager_tb.sv
